@@ design/ffca_pkg.sv @@
package ffca_pkg;

    // Default pool geometry
    localparam int CLUSTER_COUNT_DEF = 256;
    localparam int CLUSTER_BYTES_DEF = 64;

    // Fixed field widths
    localparam int BYTE_W = 16;
    localparam int IDX_W  = 8;

    // Command codes
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic clr_step;     // write one zero entry of the clearing pass
        logic acc_free;     // free beat accepted: clear entry, report done
        logic acc_alloc;    // allocate beat accepted: register the cluster count
        logic scan_init;    // start the map walk at cluster 0
        logic scan_step;    // advance the map walk by one entry
        logic resp_fail;    // report a failed allocation
        logic grant_write;  // record the fragment and report the grant
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic clr_last;     // clearing pass on its last entry
        logic need_bad;     // cluster count zero or beyond the pool
        logic scan_end;     // walk has run off the end of the map
        logic scan_hit;     // current entry completes a long enough run
    } t_dp_stat;

endpackage

@@ design/ffca_ctrl.sv @@
module ffca_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic               i_command,
    input  ffca_pkg::t_dp_stat i_stat,
    output ffca_pkg::t_dp_cmd  o_cmd,
    output logic               busy
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_SCAN
    } t_state;

    t_state r_state, n_state;
    logic   r_busy, n_busy;

    // Decode state into datapath commands and the next state
    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        n_busy  = r_busy;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                    n_busy  = 1'b0;
                end
            end
            S_IDLE: begin
                if (start) begin
                    if (i_command == ffca_pkg::CMD_FREE) begin
                        o_cmd.acc_free = 1'b1;
                    end else begin
                        o_cmd.acc_alloc = 1'b1;
                        n_state         = S_CHECK;
                        n_busy          = 1'b1;
                    end
                end
            end
            S_CHECK: begin
                if (i_stat.need_bad) begin
                    o_cmd.resp_fail = 1'b1;
                    n_state         = S_IDLE;
                    n_busy          = 1'b0;
                end else begin
                    o_cmd.scan_init = 1'b1;
                    n_state         = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_stat.scan_end) begin
                    o_cmd.resp_fail = 1'b1;
                    n_state         = S_IDLE;
                    n_busy          = 1'b0;
                end else if (i_stat.scan_hit) begin
                    o_cmd.grant_write = 1'b1;
                    n_state           = S_IDLE;
                    n_busy            = 1'b0;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            default: begin
                n_state = S_CLEAR;
                n_busy  = 1'b1;
            end
        endcase
    end

    // Hold state and the busy flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_busy  <= 1'b1;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
        end
    end

    assign busy = r_busy;

endmodule

@@ design/ffca_dpath.sv @@
module ffca_dpath #(
    parameter int CLUSTER_COUNT = ffca_pkg::CLUSTER_COUNT_DEF,
    parameter int CLUSTER_BYTES = ffca_pkg::CLUSTER_BYTES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  ffca_pkg::t_dp_cmd            i_cmd,
    output ffca_pkg::t_dp_stat           o_stat,
    input  logic [ffca_pkg::BYTE_W-1:0]  i_byte_count,
    input  logic [ffca_pkg::IDX_W-1:0]   i_free_index,
    output logic                         o_done,
    output logic                         o_granted,
    output logic [ffca_pkg::IDX_W-1:0]   o_start_cluster
);

    localparam int BYTE_W = ffca_pkg::BYTE_W;
    localparam int IDX_W  = ffca_pkg::IDX_W;
    localparam int AW     = $clog2(CLUSTER_COUNT);        // map address
    localparam int LW     = $clog2(CLUSTER_COUNT + 1);    // length / position
    localparam int NW     = BYTE_W + 1;                   // padded bytes, cluster count
    localparam int SH     = NW + $clog2(CLUSTER_BYTES);   // reciprocal scale
    localparam int MW     = NW + 1;                       // reciprocal width
    localparam int PW     = NW + MW;                      // product width

    // Reciprocal of the cluster size, exact for any NW-bit dividend
    localparam longint RECIP_L = ((longint'(1) << SH) / longint'(CLUSTER_BYTES))
                               + longint'(1);
    localparam logic [MW-1:0] RECIP = MW'(RECIP_L);

    // Allocation map
    logic [LW-1:0]     r_mem [CLUSTER_COUNT];
    logic [LW-1:0]     r_rdata;
    logic [AW-1:0]     rd_addr;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [LW-1:0]     wr_data;

    // Clearing pass
    logic [AW-1:0]     r_clr_cnt;

    // Cluster count
    logic [NW-1:0]     byte_pad;
    logic [PW-1:0]     need_prod;
    logic [NW-1:0]     need_calc;
    logic [NW-1:0]     r_need;
    logic [LW-1:0]     need_len;

    // Map walk
    logic [LW-1:0]     r_pos;
    logic [LW-1:0]     r_run_start;
    logic [LW-1:0]     r_run_len;
    logic              pos_end;
    logic              frag_zero;
    logic [LW-1:0]     len_nx;
    logic [LW-1:0]     pos_nx;
    logic              free_ok;

    // Result beat
    logic              r_done;
    logic              r_granted;
    logic [IDX_W-1:0]  r_start;

    // Round up to whole clusters: pad, then divide by reciprocal multiplication
    assign byte_pad  = NW'(i_byte_count) + NW'(CLUSTER_BYTES - 1);
    assign need_prod = PW'(byte_pad) * PW'(RECIP);
    assign need_calc = NW'(need_prod >> SH);
    assign need_len  = r_need[LW-1:0];

    // Walk step on the entry read last cycle
    assign pos_end   = r_pos >= LW'(CLUSTER_COUNT);
    assign frag_zero = r_rdata == '0;
    assign len_nx    = r_run_len + LW'(1);
    assign pos_nx    = frag_zero ? (r_pos + LW'(1)) : (r_pos + r_rdata);

    // Read address: cluster 0 to start the walk, else the next position
    always_comb begin
        if (i_cmd.scan_init) begin
            rd_addr = '0;
        end else if (pos_nx < LW'(CLUSTER_COUNT)) begin
            rd_addr = pos_nx[AW-1:0];
        end else begin
            rd_addr = '0;
        end
    end

    assign free_ok = 32'(i_free_index) < 32'(CLUSTER_COUNT);

    // Select the single map write
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_clr_cnt;
        wr_data = '0;
        if (i_cmd.clr_step) begin
            wr_en   = 1'b1;
            wr_addr = r_clr_cnt;
        end else if (i_cmd.acc_free && free_ok) begin
            wr_en   = 1'b1;
            wr_addr = AW'(i_free_index);
        end else if (i_cmd.grant_write) begin
            wr_en   = 1'b1;
            wr_addr = r_run_start[AW-1:0];
            wr_data = need_len;
        end
    end

    // Map port: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rdata <= r_mem[rd_addr];
    end

    // Advance the clearing pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr_cnt <= r_clr_cnt + AW'(1);
        end
    end

    // Hold the cluster count of the accepted allocate beat
    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_alloc) begin
            r_need <= need_calc;
        end
    end

    // Walk the map, skipping allocated fragments by their length
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_init) begin
            r_pos       <= '0;
            r_run_start <= '0;
            r_run_len   <= '0;
        end else if (i_cmd.scan_step) begin
            r_pos <= pos_nx;
            if (frag_zero) begin
                r_run_len <= len_nx;
            end else begin
                r_run_start <= pos_nx;
                r_run_len   <= '0;
            end
        end
    end

    // Register the result beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.acc_free | i_cmd.resp_fail | i_cmd.grant_write;
        end
    end

    always_ff @(posedge i_clk) begin
        r_granted <= !i_cmd.resp_fail;
        r_start   <= i_cmd.grant_write ? IDX_W'(r_run_start) : '0;
    end

    assign o_stat.clr_last = r_clr_cnt == AW'(CLUSTER_COUNT - 1);
    assign o_stat.need_bad = (r_need == '0) || (r_need > NW'(CLUSTER_COUNT));
    assign o_stat.scan_end = pos_end;
    assign o_stat.scan_hit = !pos_end && frag_zero && (len_nx == need_len);

    assign o_done          = r_done;
    assign o_granted       = r_granted;
    assign o_start_cluster = r_start;

endmodule

@@ design/first_fit_cluster_allocator_core.sv @@
// Channel   Direction  Handshake                       Payload
// request   in         start high while busy is low    i_command, i_byte_count, i_free_index
// result    out        o_done high for one cycle       o_granted, o_start_cluster
//
// A free is answered in the next cycle; busy stays low, so frees may follow back to back.
// An allocate runs a size check, then a walk over the map entries, then the
// result register; the cluster count is rounded up by a reciprocal multiply
// as the beat is taken, and the registered read of the allocation map paces
// the walk.
// After reset a clearing pass zeroes the map one entry at a time, with
// busy held high. The result beat is shown for one cycle and cannot be stalled.
module first_fit_cluster_allocator_core #(
    parameter int CLUSTER_COUNT = ffca_pkg::CLUSTER_COUNT_DEF,
    parameter int CLUSTER_BYTES = ffca_pkg::CLUSTER_BYTES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        i_command,
    input  logic [ffca_pkg::BYTE_W-1:0] i_byte_count,
    input  logic [ffca_pkg::IDX_W-1:0]  i_free_index,
    output logic                        o_done,
    output logic                        o_granted,
    output logic [ffca_pkg::IDX_W-1:0]  o_start_cluster
);

    ffca_pkg::t_dp_cmd  dp_cmd;
    ffca_pkg::t_dp_stat dp_stat;

    ffca_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .i_command (i_command),
        .i_stat    (dp_stat),
        .o_cmd     (dp_cmd),
        .busy      (busy)
    );

    ffca_dpath #(
        .CLUSTER_COUNT (CLUSTER_COUNT),
        .CLUSTER_BYTES (CLUSTER_BYTES)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (dp_cmd),
        .o_stat          (dp_stat),
        .i_byte_count    (i_byte_count),
        .i_free_index    (i_free_index),
        .o_done          (o_done),
        .o_granted       (o_granted),
        .o_start_cluster (o_start_cluster)
    );

endmodule

@@ design/ffca_checker.sv @@
module ffca_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        i_command,
    input logic                        o_done,
    input logic                        o_granted,
    input logic [ffca_pkg::IDX_W-1:0]  o_start_cluster
);

    // A failed allocation reports cluster zero
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_granted) |-> (o_start_cluster == '0))
        else $error("failed allocation with nonzero start cluster");

    // A free beat is answered in the next cycle with a plain grant
    a_free_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_command == ffca_pkg::CMD_FREE))
        |=> (o_done && o_granted && (o_start_cluster == '0)))
        else $error("free beat not answered in the next cycle");

    // An allocate beat occupies the block
    a_alloc_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_command == ffca_pkg::CMD_ALLOC)) |=> busy)
        else $error("busy not raised after an allocate beat");

    // Results appear only once the block is free again
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result beat while busy");

endmodule

bind first_fit_cluster_allocator_core ffca_checker u_ffca_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .i_command       (i_command),
    .o_done          (o_done),
    .o_granted       (o_granted),
    .o_start_cluster (o_start_cluster)
);

@@ test/ffca_grant_checker.sv @@
module ffca_grant_checker
    import ffca_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  logic              busy,
    input  logic              i_command,
    input  logic [BYTE_W-1:0] i_byte_count,
    input  logic [IDX_W-1:0]  i_free_index,
    input  logic              o_done,
    input  logic              o_granted,
    input  logic [IDX_W-1:0]  o_start_cluster,
    output int                mismatch_count,
    output int                outstanding
);

    typedef struct packed {
        logic             granted;
        logic [IDX_W-1:0] start_cluster;
    } grant_beat_t;

    // Shadow allocation map: fragment length at each start cluster
    logic [8:0]  frag_len [CLUSTER_COUNT_DEF];
    grant_beat_t expected_grants [$];

    // Apply one request beat to the shadow map and work out its result
    function automatic grant_beat_t predict_grant(logic cmd, logic [BYTE_W-1:0] bytes,
                                                  logic [IDX_W-1:0] idx);
        grant_beat_t res;
        int          need;
        int          pos;
        int          run_start;
        int          run_len;
        logic        found;
        res       = '0;
        found     = 1'b0;
        pos       = 0;
        run_start = 0;
        run_len   = 0;
        if (cmd == CMD_FREE) begin
            if (int'(idx) < CLUSTER_COUNT_DEF)
                frag_len[idx] = '0;
            res.granted = 1'b1;
            return res;
        end
        // Round up to whole clusters; zero-size and oversize requests fail
        need = (int'(bytes) + CLUSTER_BYTES_DEF - 1) / CLUSTER_BYTES_DEF;
        if (need == 0 || need > CLUSTER_COUNT_DEF)
            return res;
        // First-fit walk, jumping over each allocated fragment by its length
        while (pos < CLUSTER_COUNT_DEF && !found) begin
            if (frag_len[pos] != 0) begin
                pos       = pos + int'(frag_len[pos]);
                run_start = pos;
                run_len   = 0;
            end else begin
                run_len = run_len + 1;
                if (run_len == need)
                    found = 1'b1;
                else
                    pos = pos + 1;
            end
        end
        if (found) begin
            frag_len[run_start] = 9'(need);
            res.granted         = 1'b1;
            res.start_cluster   = IDX_W'(run_start);
        end
        return res;
    endfunction

    // Compare each result beat with the oldest expectation, then record new requests
    always @(posedge i_clk) begin
        grant_beat_t exp_beat;
        if (!i_rst_n) begin
            foreach (frag_len[i])
                frag_len[i] = '0;
            expected_grants.delete();
            mismatch_count = 0;
        end else begin
            if (o_done) begin
                if (expected_grants.size() == 0) begin
                    $display("%0t: unexpected result beat: granted=%0d start_cluster=%0d",
                             $time, o_granted, o_start_cluster);
                    mismatch_count = mismatch_count + 1;
                end else begin
                    exp_beat = expected_grants.pop_front();
                    if (o_granted !== exp_beat.granted) begin
                        $display("%0t: granted expected %0d, actual %0d",
                                 $time, exp_beat.granted, o_granted);
                        mismatch_count = mismatch_count + 1;
                    end
                    if (o_start_cluster !== exp_beat.start_cluster) begin
                        $display("%0t: start_cluster expected %0d, actual %0d",
                                 $time, exp_beat.start_cluster, o_start_cluster);
                        mismatch_count = mismatch_count + 1;
                    end
                end
            end
            if (start && !busy)
                expected_grants.push_back(predict_grant(i_command, i_byte_count,
                                                        i_free_index));
        end
        outstanding = expected_grants.size();
    end

endmodule

@@ test/tb_top.sv @@
module tb_top;
    import ffca_pkg::*;

    localparam int STALL_LIMIT   = 1500;
    localparam int RANDOM_ITEMS  = 1400;
    localparam int DRAIN_CYCLES  = 300;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic              i_command;
    logic [BYTE_W-1:0] i_byte_count;
    logic [IDX_W-1:0]  i_free_index;
    logic              o_done;
    logic              o_granted;
    logic [IDX_W-1:0]  o_start_cluster;

    int   mismatch_count;
    int   outstanding;
    logic beat_taken;
    int   idle_pct;
    int   stall_cycles;
    logic cmd_in_flight [$];
    int   live_starts [$];

    first_fit_cluster_allocator_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_command      (i_command),
        .i_byte_count   (i_byte_count),
        .i_free_index   (i_free_index),
        .o_done         (o_done),
        .o_granted      (o_granted),
        .o_start_cluster(o_start_cluster)
    );

    ffca_grant_checker checker_i (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_command      (i_command),
        .i_byte_count   (i_byte_count),
        .i_free_index   (i_free_index),
        .o_done         (o_done),
        .o_granted      (o_granted),
        .o_start_cluster(o_start_cluster),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Note each accepted beat and keep track of granted fragments for later frees
    always @(posedge i_clk) begin
        logic cmd;
        beat_taken <= i_rst_n && start && !busy;
        if (i_rst_n && o_done && cmd_in_flight.size() > 0) begin
            cmd = cmd_in_flight.pop_front();
            if (cmd == CMD_ALLOC && o_granted)
                live_starts.push_back(int'(o_start_cluster));
        end
        if (i_rst_n && start && !busy)
            cmd_in_flight.push_back(i_command);
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done)
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else
            stall_cycles <= stall_cycles + 1;
    end

    // Offer one request beat, first idling while a draw under idle_pct in a hundred comes up; hold until taken
    task automatic send_request(logic cmd, logic [BYTE_W-1:0] bytes, logic [IDX_W-1:0] idx);
        while ($urandom_range(99) < idle_pct) begin
            start        <= 1'b0;
            i_command    <= 1'($urandom);
            i_byte_count <= BYTE_W'($urandom);
            i_free_index <= IDX_W'($urandom);
            @(negedge i_clk);
        end
        start        <= 1'b1;
        i_command    <= cmd;
        i_byte_count <= bytes;
        i_free_index <= idx;
        do @(negedge i_clk); while (!beat_taken);
    endtask

    task automatic alloc_bytes(logic [BYTE_W-1:0] bytes);
        send_request(CMD_ALLOC, bytes, IDX_W'($urandom));
    endtask

    task automatic free_cluster(logic [IDX_W-1:0] idx);
        send_request(CMD_FREE, BYTE_W'($urandom), idx);
    endtask

    // Random beat: frees lean on live fragments, sizes mostly modest to churn the map
    task automatic random_request();
        int          pick;
        int          r;
        logic [15:0] bytes;
        r = $urandom_range(99);
        if (live_starts.size() > 0 && r < (live_starts.size() > 12 ? 55 : 30)) begin
            pick = $urandom_range(live_starts.size() - 1);
            free_cluster(IDX_W'(live_starts[pick]));
            live_starts.delete(pick);
        end else if (r < 42) begin
            free_cluster(IDX_W'($urandom));
        end else begin
            r = $urandom_range(99);
            if (r < 65)
                bytes = 16'($urandom_range(1, CLUSTER_BYTES_DEF * 24));
            else if (r < 78)
                bytes = 16'($urandom_range(1, 24) * CLUSTER_BYTES_DEF);
            else if (r < 88)
                bytes = 16'($urandom);
            else if (r < 94)
                bytes = 16'($urandom_range(16000, 16500));
            else
                bytes = 16'($urandom_range(0, 2));
            alloc_bytes(bytes);
        end
    endtask

    initial begin
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_command    = CMD_ALLOC;
        i_byte_count = '0;
        i_free_index = '0;
        beat_taken   = 1'b0;
        stall_cycles = 0;
        idle_pct     = 11;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: size limits, exact full pool, no-fit, edge clusters
        alloc_bytes(16'd0);
        alloc_bytes(16'd1);
        alloc_bytes(16'd64);
        alloc_bytes(16'd65);
        alloc_bytes(16'hFFFF);
        alloc_bytes(16'd16385);
        free_cluster(8'd0);
        free_cluster(8'd1);
        free_cluster(8'd3);
        alloc_bytes(16'd128);
        free_cluster(8'd2);
        free_cluster(8'd0);
        alloc_bytes(16'd16384);
        alloc_bytes(16'd1);
        free_cluster(8'd255);
        free_cluster(8'd0);
        alloc_bytes(16'd16320);
        alloc_bytes(16'd64);
        alloc_bytes(16'd1);
        free_cluster(8'd255);
        free_cluster(8'd0);
        live_starts.delete();

        // Random: three phases of sender idling
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == RANDOM_ITEMS / 3)
                idle_pct = 65;
            else if (i == 2 * RANDOM_ITEMS / 3)
                idle_pct = 0;
            random_request();
        end
        start <= 1'b0;

        // Drain outstanding results, then let the block settle
        while (outstanding != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatch_count == 0 && outstanding == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

@@ sim.f @@
design/ffca_pkg.sv
design/ffca_ctrl.sv
design/ffca_dpath.sv
design/first_fit_cluster_allocator_core.sv
design/ffca_checker.sv
test/ffca_grant_checker.sv
test/tb_top.sv
